[hdl/tent_pkg.sv]
// Shared types, codes and constants of the triangle edge neighbour table.
package tent_pkg;

  localparam int DefTableDepth   = 8192;
  localparam int DefMaxTriangles = 2048;
  localparam int DefIdBits       = 24;

  localparam int TriW   = 11;
  localparam int NodeW  = 24;
  localparam int OwnerW = 13;

  localparam logic [63:0] MixC1 = 64'hff51afd7ed558ccd;
  localparam logic [63:0] MixC2 = 64'hc4ceb9fe1a85ec53;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_QUERY  = 2'd1;
  localparam logic [1:0] CMD_CLEAR  = 2'd2;

  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_DUP  = 2'd1;
  localparam logic [1:0] STATUS_FULL = 2'd2;

  typedef enum logic [1:0] {
    KIND_INSERT,
    KIND_QUERY,
    KIND_CLEAR,
    KIND_NOP
  } kind_t;

  typedef enum logic [2:0] {
    MX_IDLE,
    MX_PRE,
    MX_M0,
    MX_M1,
    MX_M2,
    MX_POST,
    MX_MOD
  } mix_state_t;

  typedef enum logic [2:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_START,
    BK_HWAIT,
    BK_READ,
    BK_CHECK,
    BK_OUT
  } back_state_t;

  // Handshake between the back end and the hash unit.
  typedef struct packed {
    logic start;
    logic done;
  } mix_ctl_t;

endpackage

[hdl/tent_fifo.sv]
// Two-entry queue between the front and the back end.
module tent_fifo import tent_pkg::*; #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] pop_data,
  output logic         empty
);

  logic [W-1:0] mem [2];
  logic         wr_ptr;
  logic         rd_ptr;
  logic [1:0]   count;

  assign full     = (count == 2'd2);
  assign empty    = (count == 2'd0);
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push && !full) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop && !empty) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'((push && !full) ? 1 : 0) - 2'((pop && !empty) ? 1 : 0);
    end
  end

endmodule

[hdl/tent_front.sv]
// Front end: takes input transfers, classifies them and builds the edge pairs.
module tent_front import tent_pkg::*; #(
  parameter int MAX_TRIANGLES = DefMaxTriangles,
  parameter int ID_BITS       = DefIdBits,
  localparam int ItemW        = 2 + TriW + 6 * ID_BITS
) (
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [1:0]       command,
  input  logic [TriW-1:0]  triangle_index,
  input  logic [NodeW-1:0] node_0,
  input  logic [NodeW-1:0] node_1,
  input  logic [NodeW-1:0] node_2,
  input  logic             q_full,
  output logic             q_push,
  output logic [ItemW-1:0] q_data
);

  logic [31:0]        ext0, ext1, ext2;
  logic [ID_BITS-1:0] id0, id1, id2;
  kind_t              kind;

  assign ext0 = 32'(node_0);
  assign ext1 = 32'(node_1);
  assign ext2 = 32'(node_2);
  assign id0  = ext0[ID_BITS-1:0];
  assign id1  = ext1[ID_BITS-1:0];
  assign id2  = ext2[ID_BITS-1:0];

  always_comb begin
    case (command)
      CMD_INSERT: kind = (32'(triangle_index) < 32'(MAX_TRIANGLES)) ? KIND_INSERT : KIND_NOP;
      CMD_QUERY:  kind = KIND_QUERY;
      CMD_CLEAR:  kind = KIND_CLEAR;
      default:    kind = KIND_NOP;
    endcase
  end

  // Insert stores edges (n1,n2), (n2,n0), (n0,n1); a query looks up their reverses.
  always_comb begin
    if (kind == KIND_QUERY) begin
      q_data = {kind, triangle_index, id2, id1, id0, id2, id1, id0};
    end else begin
      q_data = {kind, triangle_index, id1, id2, id2, id0, id0, id1};
    end
  end

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

endmodule

[hdl/tent_mix.sv]
// Hash unit: bitmix of both ids XORed, reduced to a slot, one 32x32 multiplier.
module tent_mix import tent_pkg::*; #(
  parameter int TABLE_DEPTH = DefTableDepth,
  parameter int ID_BITS     = DefIdBits,
  localparam int AW         = $clog2(TABLE_DEPTH)
) (
  input  logic               clk,
  input  logic               rst,
  input  mix_ctl_t           ctl_in,
  output mix_ctl_t           ctl_out,
  input  logic [ID_BITS-1:0] id_a,
  input  logic [ID_BITS-1:0] id_b,
  output logic [AW-1:0]      slot
);

  localparam bit IsPow2 = (TABLE_DEPTH & (TABLE_DEPTH - 1)) == 0;
  // 2^32 mod TABLE_DEPTH folds the upper word of the hash into the lower one;
  // the reciprocal then estimates the quotient of the folded word.
  localparam logic [31:0] FoldR     = 32'((64'd1 << 32) % 64'(TABLE_DEPTH));
  localparam logic [31:0] Recip     = 32'((64'd1 << 32) / 64'(TABLE_DEPTH));
  localparam logic [31:0] DepthW    = 32'(TABLE_DEPTH);
  localparam logic [3:0]  StepRecip = 4'd5;
  localparam logic [3:0]  StepBack  = 4'd6;
  localparam logic [3:0]  StepLast  = 4'd7;

  mix_state_t        state, state_next;
  logic [63:0]       v, acc, h, pb;
  logic              second, which;
  logic [3:0]        step_cnt;
  logic [AW-1:0]     rem;
  logic [31:0]       mx, my;
  logic [63:0]       prod;
  logic [63:0]       konst;
  logic [63:0]       post;
  logic              finish, done_q;

  assign konst   = second ? MixC2 : MixC1;
  assign prod    = 64'(mx) * 64'(my);
  assign post    = acc ^ (acc >> 33);
  assign slot    = rem;

  always_comb begin
    mx = v[31:0];
    my = konst[31:0];
    case (state)
      MX_M1: my = konst[63:32];
      MX_M2: mx = v[63:32];
      MX_MOD: begin
        if (step_cnt < StepRecip) begin
          mx = h[63:32];
          my = FoldR;
        end else if (step_cnt == StepRecip) begin
          mx = h[31:0];
          my = Recip;
        end else begin
          mx = acc[31:0];
          my = DepthW;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    state_next    = state;
    ctl_out.done  = done_q;
    ctl_out.start = 1'b0;
    case (state)
      MX_IDLE: if (ctl_in.start) state_next = MX_PRE;
      MX_PRE:  state_next = MX_M0;
      MX_M0:   state_next = MX_M1;
      MX_M1:   state_next = MX_M2;
      MX_M2:   state_next = MX_POST;
      MX_POST: begin
        if (!second) begin
          state_next = MX_M0;
        end else if (!which) begin
          state_next = MX_PRE;
        end else if (IsPow2) begin
          state_next = MX_IDLE;
        end else begin
          state_next = MX_MOD;
        end
      end
      MX_MOD: if (step_cnt == StepLast) state_next = MX_IDLE;
      default: state_next = MX_IDLE;
    endcase
    finish = (state == MX_POST && second && which && IsPow2) ||
             (state == MX_MOD && step_cnt == StepLast);
  end

  // Done is registered, so it rises together with the final value of the slot register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= MX_IDLE;
      done_q <= 1'b0;
    end else begin
      state  <= state_next;
      done_q <= finish;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      MX_IDLE: begin
        v      <= 64'(id_a);
        pb     <= 64'(id_b);
        second <= 1'b0;
        which  <= 1'b0;
        h      <= '0;
      end
      MX_PRE: begin
        v      <= v ^ (v >> 33);
        second <= 1'b0;
      end
      MX_M0: acc <= prod;
      MX_M1, MX_M2: acc[63:32] <= acc[63:32] + prod[31:0];
      MX_POST: begin
        if (!second) begin
          v      <= post;
          second <= 1'b1;
        end else begin
          h        <= h ^ post;
          which    <= 1'b1;
          v        <= pb;
          step_cnt <= '0;
          if (IsPow2) begin
            rem <= AW'(h ^ post);
          end
        end
      end
      // Five folds bring the hash below 2^32, a reciprocal multiply estimates
      // the quotient to within one, and one compare and subtract finishes.
      MX_MOD: begin
        step_cnt <= step_cnt + 4'd1;
        if (step_cnt < StepRecip) begin
          h <= prod + {32'd0, h[31:0]};
        end else if (step_cnt == StepRecip) begin
          acc <= {32'd0, prod[63:32]};
        end else if (step_cnt == StepBack) begin
          h <= {32'd0, h[31:0] - prod[31:0]};
        end else begin
          rem <= (h[31:0] >= DepthW) ? AW'(h[31:0] - DepthW) : AW'(h[31:0]);
        end
      end
      default: ;
    endcase
  end

endmodule

[hdl/tent_back.sv]
// Back end: clears and probes the slot memory, inserts or looks up edges, holds the result.
module tent_back import tent_pkg::*; #(
  parameter int TABLE_DEPTH = DefTableDepth,
  parameter int ID_BITS     = DefIdBits,
  localparam int AW         = $clog2(TABLE_DEPTH),
  localparam int ItemW      = 2 + TriW + 6 * ID_BITS,
  localparam int KeyW       = 2 * ID_BITS,
  localparam int EntW       = 1 + KeyW + OwnerW
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_empty,
  input  logic [ItemW-1:0] q_data,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [1:0]       status,
  output logic [TriW-1:0]  neighbour_0,
  output logic [TriW-1:0]  neighbour_1,
  output logic [TriW-1:0]  neighbour_2,
  output logic [1:0]       neighbour_edge_0,
  output logic [1:0]       neighbour_edge_1,
  output logic [1:0]       neighbour_edge_2,
  output logic [2:0]       found_mask,
  output logic [1:0]       boundary_count
);

  logic [EntW-1:0] mem [TABLE_DEPTH];
  logic [EntW-1:0] rdata;

  back_state_t        state, state_next;
  kind_t              kind;
  logic [TriW-1:0]    tri_id;
  logic [KeyW-1:0]    pairs [3];
  logic [1:0]         edge_no;
  logic [AW-1:0]      pos, probes, clr_addr;
  logic               err, full, pend;
  logic [TriW-1:0]    nb [3];
  logic [1:0]         ne [3];
  logic [2:0]         mask;

  mix_ctl_t           mix_in, mix_out;
  logic [AW-1:0]      mix_slot;
  logic [KeyW-1:0]    cur_key;

  logic               rd_valid, hit, last_probe, we;
  logic [AW-1:0]      waddr;
  logic [EntW-1:0]    wdata;

  assign cur_key    = pairs[edge_no];
  assign rd_valid   = rdata[EntW-1];
  assign hit        = rd_valid && (rdata[EntW-2 -: KeyW] == cur_key);
  assign last_probe = (probes == AW'(TABLE_DEPTH - 1));

  tent_mix #(.TABLE_DEPTH(TABLE_DEPTH), .ID_BITS(ID_BITS)) u_mix (
    .clk    (clk),
    .rst    (rst),
    .ctl_in (mix_in),
    .ctl_out(mix_out),
    .id_a   (cur_key[KeyW-1:ID_BITS]),
    .id_b   (cur_key[ID_BITS-1:0]),
    .slot   (mix_slot)
  );

  always_comb begin
    state_next   = state;
    q_pop        = 1'b0;
    mix_in.start = 1'b0;
    mix_in.done  = 1'b0;
    we           = 1'b0;
    waddr        = pos;
    wdata        = {1'b1, cur_key, tri_id, edge_no};
    case (state)
      BK_CLEAR: begin
        we    = 1'b1;
        waddr = clr_addr;
        wdata = '0;
        if (clr_addr == AW'(TABLE_DEPTH - 1)) state_next = pend ? BK_OUT : BK_IDLE;
      end
      BK_IDLE: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          case (kind_t'(q_data[ItemW-1 -: 2]))
            KIND_CLEAR:  state_next = BK_CLEAR;
            KIND_NOP:    state_next = BK_OUT;
            KIND_INSERT: state_next = err ? BK_OUT : BK_START;
            default:     state_next = BK_START;
          endcase
        end
      end
      BK_START: begin
        mix_in.start = 1'b1;
        state_next   = BK_HWAIT;
      end
      BK_HWAIT: if (mix_out.done) state_next = BK_READ;
      BK_READ:  state_next = BK_CHECK;
      BK_CHECK: begin
        if (!rd_valid) begin
          we         = (kind == KIND_INSERT);
          state_next = (edge_no == 2'd2) ? BK_OUT : BK_START;
        end else if (hit) begin
          if (kind == KIND_INSERT) state_next = BK_OUT;
          else state_next = (edge_no == 2'd2) ? BK_OUT : BK_START;
        end else if (last_probe) begin
          if (kind == KIND_INSERT) state_next = BK_OUT;
          else state_next = (edge_no == 2'd2) ? BK_OUT : BK_START;
        end else begin
          state_next = BK_READ;
        end
      end
      BK_OUT: if (!out_valid || out_ready) state_next = BK_IDLE;
      default: state_next = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[pos];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_CLEAR;
      clr_addr  <= '0;
      pend      <= 1'b0;
      err       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_valid && out_ready && state != BK_OUT) begin
        out_valid <= 1'b0;
      end
      case (state)
        BK_CLEAR: begin
          clr_addr <= (clr_addr == AW'(TABLE_DEPTH - 1)) ? '0 : clr_addr + AW'(1);
          if (clr_addr == AW'(TABLE_DEPTH - 1)) begin
            err <= 1'b0;
          end
        end
        BK_IDLE: begin
          if (!q_empty) begin
            kind     <= kind_t'(q_data[ItemW-1 -: 2]);
            tri_id   <= q_data[ItemW-3 -: TriW];
            pairs[0] <= q_data[6*ID_BITS-1 -: KeyW];
            pairs[1] <= q_data[4*ID_BITS-1 -: KeyW];
            pairs[2] <= q_data[2*ID_BITS-1 -: KeyW];
            pend     <= (kind_t'(q_data[ItemW-1 -: 2]) == KIND_CLEAR);
            edge_no  <= 2'd0;
            full     <= 1'b0;
            mask     <= '0;
            for (int i = 0; i < 3; i++) begin
              nb[i] <= '0;
              ne[i] <= '0;
            end
          end
        end
        BK_HWAIT: begin
          pos    <= mix_slot;
          probes <= '0;
        end
        BK_CHECK: begin
          if (!rd_valid || hit || last_probe) begin
            edge_no <= edge_no + 2'd1;
            if (hit && kind == KIND_INSERT) err <= 1'b1;
            if (hit && kind == KIND_QUERY) begin
              nb[edge_no]   <= rdata[OwnerW-1:2];
              ne[edge_no]   <= rdata[1:0];
              mask[edge_no] <= 1'b1;
            end
            if (rd_valid && !hit && kind == KIND_INSERT) full <= 1'b1;
          end else begin
            probes <= probes + AW'(1);
            pos    <= (pos == AW'(TABLE_DEPTH - 1)) ? '0 : pos + AW'(1);
          end
        end
        BK_OUT: begin
          if (!out_valid || out_ready) begin
            out_valid        <= 1'b1;
            pend             <= 1'b0;
            status           <= err ? STATUS_DUP : (full ? STATUS_FULL : STATUS_OK);
            neighbour_0      <= nb[0];
            neighbour_1      <= nb[1];
            neighbour_2      <= nb[2];
            neighbour_edge_0 <= ne[0];
            neighbour_edge_1 <= ne[1];
            neighbour_edge_2 <= ne[2];
            found_mask       <= mask;
            boundary_count   <= (kind == KIND_QUERY) ?
                                2'(3 - ({1'b0, mask[0]} + {1'b0, mask[1]} + {1'b0, mask[2]}))
                                : 2'd0;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

[hdl/triangle_edge_neighbour_table.sv]
// Top level of the triangle edge neighbour table.
//
// This block builds the edge adjacency of a triangle mesh in a hash table of
// directed edges held in one on-chip memory of TABLE_DEPTH slots. An insert
// transfer stores the three directed edges of a triangle, a query transfer
// looks up the three reversed edges and returns the neighbouring triangles,
// and a clear transfer empties the table and the sticky duplicate error.
// Every input transfer yields exactly one output transfer. Items are handled
// one at a time by the back end; a front end and a two-entry queue take new
// transfers while the back end works, and the result register lets the
// back end go on while a result waits to be taken. Each edge costs one pass
// through the shared hash unit, with its single 32x32 multiplier and a
// remainder reduction when TABLE_DEPTH is not a power of two, and then a
// read state and a check state per probed slot, since every memory read is
// registered. After reset, and for every clear command, the block sweeps
// the memory once, clearing every slot, before it takes up the next queued
// item.
module triangle_edge_neighbour_table import tent_pkg::*; #(
  parameter int TABLE_DEPTH   = DefTableDepth,
  parameter int MAX_TRIANGLES = DefMaxTriangles,
  parameter int ID_BITS       = DefIdBits
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: triangle_index[10:0], node_0[34:11], node_1[58:35], node_2[82:59], zero pad
  input  logic [87:0] s_axis_tdata,
  // tuser: command[1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: neighbour_0[10:0], neighbour_1[21:11], neighbour_2[32:22],
  // neighbour_edge_0[34:33], neighbour_edge_1[36:35], neighbour_edge_2[38:37],
  // found_mask[41:39], boundary_count[43:42], zero pad
  output logic [47:0] m_axis_tdata,
  // tuser: status[1:0]
  output logic [1:0]  m_axis_tuser
);

  localparam int ItemW = 2 + TriW + 6 * ID_BITS;

  logic             q_push, q_full, q_pop, q_empty;
  logic [ItemW-1:0] q_in, q_out;

  logic [TriW-1:0] nb0, nb1, nb2;
  logic [1:0]      ne0, ne1, ne2;
  logic [2:0]      mask;
  logic [1:0]      bcount;

  tent_front #(.MAX_TRIANGLES(MAX_TRIANGLES), .ID_BITS(ID_BITS)) u_front (
    .in_valid      (s_axis_tvalid),
    .in_ready      (s_axis_tready),
    .command       (s_axis_tuser),
    .triangle_index(s_axis_tdata[10:0]),
    .node_0        (s_axis_tdata[34:11]),
    .node_1        (s_axis_tdata[58:35]),
    .node_2        (s_axis_tdata[82:59]),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_data        (q_in)
  );

  tent_fifo #(.W(ItemW)) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_data(q_in),
    .full     (q_full),
    .pop      (q_pop),
    .pop_data (q_out),
    .empty    (q_empty)
  );

  tent_back #(.TABLE_DEPTH(TABLE_DEPTH), .ID_BITS(ID_BITS)) u_back (
    .clk             (clk),
    .rst             (rst),
    .q_empty         (q_empty),
    .q_data          (q_out),
    .q_pop           (q_pop),
    .out_valid       (m_axis_tvalid),
    .out_ready       (m_axis_tready),
    .status          (m_axis_tuser),
    .neighbour_0     (nb0),
    .neighbour_1     (nb1),
    .neighbour_2     (nb2),
    .neighbour_edge_0(ne0),
    .neighbour_edge_1(ne1),
    .neighbour_edge_2(ne2),
    .found_mask      (mask),
    .boundary_count  (bcount)
  );

  assign m_axis_tdata = {4'd0, bcount, mask, ne2, ne1, ne0, nb2, nb1, nb0};

endmodule
